### sv/gda_pkg.sv
`default_nettype none
package gda_pkg;

	localparam int MAX_YEAR   = 9999;
	localparam int COUNT_BITS = 10;

	localparam int CMD_W  = 3;
	localparam int AMT_W  = 10;
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;

	// Year split into year / 100 and year % 100 for the leap rule.
	localparam int HI_W     = 8;
	localparam int LO_W     = 7;
	localparam int RECIP    = 5243;
	localparam int RECIP_SH = 19;
	localparam int PROD_W   = 27;

	localparam int DCNT_W = 13;
	localparam int YADD_W = 20;

	localparam logic [AMT_W-1:0] AMT_MASK = AMT_W'((1 << COUNT_BITS) - 1);

	localparam logic [CMD_W-1:0] CMD_DAYS      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WEEKS     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MONTHS    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_YEARS     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DECADES   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CENTURIES = 3'd5;
	localparam logic [CMD_W-1:0] CMD_MILLENNIA = 3'd6;

	localparam logic [MON_W-1:0] MON_FEB = 4'd2;
	localparam logic [MON_W-1:0] MON_DEC = 4'd12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SPLIT,
		ST_CHECK,
		ST_RUN,
		ST_YEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [HI_W-1:0]   hi;
		logic [LO_W-1:0]   lo;
	} date_t;

	typedef struct packed {
		logic [DAY_W-1:0] month_len;
		date_t            next;
		logic             at_top;
	} step_t;

	function automatic logic is_leap(logic [HI_W-1:0] hi, logic [LO_W-1:0] lo);
		is_leap = (lo[1:0] == 2'b00) && ((lo != '0) || (hi[1:0] == 2'b00));
	endfunction

	function automatic logic [DAY_W-1:0] days_in(logic [MON_W-1:0] month, logic leap);
		logic [DAY_W-1:0] len;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		days_in = len;
	endfunction

endpackage
`default_nettype wire

### sv/gda_in_if.sv
`default_nettype none
interface gda_in_if;
	logic                         valid;
	logic                         ready;
	logic [gda_pkg::CMD_W-1:0]  command;
	logic [gda_pkg::AMT_W-1:0]  amount;
	logic [gda_pkg::DAY_W-1:0]  start_day;
	logic [gda_pkg::MON_W-1:0]  start_month;
	logic [gda_pkg::YEAR_W-1:0] start_year;

	modport source (output valid, command, amount, start_day, start_month, start_year,
		input ready);
	modport sink (input valid, command, amount, start_day, start_month, start_year,
		output ready);
endinterface
`default_nettype wire

### sv/gda_out_if.sv
`default_nettype none
interface gda_out_if;
	logic                         valid;
	logic                         ready;
	logic [gda_pkg::DAY_W-1:0]  end_day;
	logic [gda_pkg::MON_W-1:0]  end_month;
	logic [gda_pkg::YEAR_W-1:0] end_year;
	logic                         overflow;
	logic                         bad_date;

	modport source (output valid, end_day, end_month, end_year, overflow, bad_date,
		input ready);
	modport sink (input valid, end_day, end_month, end_year, overflow, bad_date,
		output ready);
endinterface
`default_nettype wire

### sv/gda_day_unit.sv
`default_nettype none
module gda_day_unit (
	input  var gda_pkg::date_t cur,
	output var gda_pkg::step_t step
);

	logic                        leap;
	logic [gda_pkg::DAY_W-1:0] len;
	logic                        end_of_month;
	logic                        lo_wrap;

	assign leap         = gda_pkg::is_leap(cur.hi, cur.lo);
	assign len          = gda_pkg::days_in(cur.month, leap);
	assign end_of_month = (cur.day >= len);
	assign lo_wrap      = (cur.lo == gda_pkg::LO_W'(99));

	always_comb begin
		step.month_len = len;
		step.next      = cur;
		step.at_top    = end_of_month && (cur.month >= gda_pkg::MON_DEC)
			&& (cur.year >= gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR));
		if (!end_of_month) begin
			step.next.day = cur.day + gda_pkg::DAY_W'(1);
		end else if (cur.month < gda_pkg::MON_DEC) begin
			step.next.day   = gda_pkg::DAY_W'(1);
			step.next.month = cur.month + gda_pkg::MON_W'(1);
		end else begin
			// New year: keep year / 100 and year % 100 in step with the year.
			step.next.day   = gda_pkg::DAY_W'(1);
			step.next.month = gda_pkg::MON_W'(1);
			step.next.year  = cur.year + gda_pkg::YEAR_W'(1);
			step.next.lo    = lo_wrap ? '0 : cur.lo + gda_pkg::LO_W'(1);
			step.next.hi    = lo_wrap ? cur.hi + gda_pkg::HI_W'(1) : cur.hi;
		end
	end

endmodule
`default_nettype wire

### sv/gda_sequencer.sv
`default_nettype none
module gda_sequencer (
	input  var logic                         clk,
	input  var logic                         arst_n,
	input  var logic                         in_valid,
	output var logic                         in_ready,
	input  var logic [gda_pkg::CMD_W-1:0]  command,
	input  var logic [gda_pkg::AMT_W-1:0]  amount,
	input  var logic [gda_pkg::DAY_W-1:0]  start_day,
	input  var logic [gda_pkg::MON_W-1:0]  start_month,
	input  var logic [gda_pkg::YEAR_W-1:0] start_year,
	output var logic                         out_valid,
	input  var logic                         out_ready,
	output var logic [gda_pkg::DAY_W-1:0]  end_day,
	output var logic [gda_pkg::MON_W-1:0]  end_month,
	output var logic [gda_pkg::YEAR_W-1:0] end_year,
	output var logic                         overflow,
	output var logic                         bad_date,
	output var gda_pkg::date_t              cur,
	input  var gda_pkg::step_t              step
);

	gda_pkg::state_t state_q, state_d;

	logic [gda_pkg::CMD_W-1:0]  cmd_q;
	logic [gda_pkg::AMT_W-1:0]  amt_q;
	gda_pkg::date_t              date_q;
	logic [gda_pkg::PROD_W-1:0] prod_q;
	logic [gda_pkg::YADD_W-1:0] yadd_q;
	logic [gda_pkg::DCNT_W-1:0] dcnt_q;
	logic [gda_pkg::AMT_W-1:0]  mcnt_q;
	logic                         ovf_q;
	logic                         bad_q;

	logic                         out_valid_q;
	logic [gda_pkg::DAY_W-1:0]  end_day_q;
	logic [gda_pkg::MON_W-1:0]  end_month_q;
	logic [gda_pkg::YEAR_W-1:0] end_year_q;
	logic                         overflow_q;
	logic                         bad_date_q;

	logic                         accept;
	logic                         invalid;
	logic                         load_out;
	logic [10:0]                  mult;
	logic [gda_pkg::HI_W-1:0]   hi_split;
	logic [gda_pkg::YADD_W:0]   year_sum;

	assign cur    = date_q;
	assign accept = in_valid && in_ready;

	assign invalid = (date_q.month == '0) || (date_q.month > gda_pkg::MON_DEC)
		|| (date_q.day == '0) || (date_q.day > step.month_len)
		|| (date_q.year == '0) || (date_q.year > gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR));

	assign hi_split = prod_q[gda_pkg::RECIP_SH +: gda_pkg::HI_W];
	assign year_sum = {{(gda_pkg::YADD_W + 1 - gda_pkg::YEAR_W){1'b0}}, date_q.year}
		+ {1'b0, yadd_q};

	always_comb begin
		unique case (cmd_q)
			gda_pkg::CMD_YEARS:     mult = 11'd1;
			gda_pkg::CMD_DECADES:   mult = 11'd10;
			gda_pkg::CMD_CENTURIES: mult = 11'd100;
			gda_pkg::CMD_MILLENNIA: mult = 11'd1000;
			default:                mult = 11'd0;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = gda_pkg::ST_MUL;
			end
			gda_pkg::ST_MUL:   state_d = gda_pkg::ST_SPLIT;
			gda_pkg::ST_SPLIT: state_d = gda_pkg::ST_CHECK;
			gda_pkg::ST_CHECK: begin
				if (invalid) begin
					state_d = gda_pkg::ST_DONE;
				end else begin
					unique case (cmd_q)
						gda_pkg::CMD_DAYS, gda_pkg::CMD_WEEKS, gda_pkg::CMD_MONTHS:
							state_d = gda_pkg::ST_RUN;
						gda_pkg::CMD_YEARS, gda_pkg::CMD_DECADES, gda_pkg::CMD_CENTURIES,
						gda_pkg::CMD_MILLENNIA:
							state_d = gda_pkg::ST_YEAR;
						default: state_d = gda_pkg::ST_DONE;
					endcase
				end
			end
			gda_pkg::ST_RUN: begin
				if ((dcnt_q != '0) && step.at_top) begin
					state_d = gda_pkg::ST_DONE;
				end else if ((dcnt_q == '0) && (mcnt_q == '0)) begin
					state_d = gda_pkg::ST_DONE;
				end
			end
			gda_pkg::ST_YEAR: state_d = gda_pkg::ST_DONE;
			gda_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = gda_pkg::ST_IDLE;
				end
			end
			default: state_d = gda_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_q        <= command;
					amt_q        <= amount & gda_pkg::AMT_MASK;
					date_q.day   <= start_day;
					date_q.month <= start_month;
					date_q.year  <= start_year;
					date_q.hi    <= '0;
					date_q.lo    <= '0;
					ovf_q        <= 1'b0;
					bad_q        <= 1'b0;
				end
			end
			gda_pkg::ST_MUL: begin
				prod_q <= gda_pkg::PROD_W'(date_q.year * gda_pkg::RECIP);
				yadd_q <= gda_pkg::YADD_W'(amt_q) * gda_pkg::YADD_W'(mult);
			end
			gda_pkg::ST_SPLIT: begin
				date_q.hi <= hi_split;
				date_q.lo <= gda_pkg::LO_W'(date_q.year - gda_pkg::YEAR_W'(hi_split * 100));
			end
			gda_pkg::ST_CHECK: begin
				bad_q  <= invalid;
				mcnt_q <= '0;
				unique case (cmd_q)
					gda_pkg::CMD_DAYS:  dcnt_q <= gda_pkg::DCNT_W'(amt_q);
					gda_pkg::CMD_WEEKS: dcnt_q <= (gda_pkg::DCNT_W'(amt_q) << 3)
						- gda_pkg::DCNT_W'(amt_q);
					gda_pkg::CMD_MONTHS: begin
						dcnt_q <= '0;
						mcnt_q <= amt_q;
					end
					default: dcnt_q <= '0;
				endcase
			end
			gda_pkg::ST_RUN: begin
				if (dcnt_q != '0) begin
					if (step.at_top) begin
						ovf_q <= 1'b1;
					end else begin
						date_q <= step.next;
						dcnt_q <= dcnt_q - gda_pkg::DCNT_W'(1);
					end
				end else if (mcnt_q != '0) begin
					// A month step is as long as the month it starts in.
					dcnt_q <= gda_pkg::DCNT_W'(step.month_len);
					mcnt_q <= mcnt_q - gda_pkg::AMT_W'(1);
				end
			end
			gda_pkg::ST_YEAR: begin
				if (year_sum > (gda_pkg::YADD_W + 1)'(gda_pkg::MAX_YEAR)) begin
					date_q.year <= gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR);
					ovf_q       <= 1'b1;
				end else begin
					date_q.year <= year_sum[gda_pkg::YEAR_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			end_day_q   <= date_q.day;
			end_month_q <= date_q.month;
			end_year_q  <= date_q.year;
			overflow_q  <= ovf_q;
			bad_date_q  <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign end_day   = end_day_q;
	assign end_month = end_month_q;
	assign end_year  = end_year_q;
	assign overflow  = overflow_q;
	assign bad_date  = bad_date_q;

endmodule
`default_nettype wire

### sv/gregorian_date_adder.sv
// Channel | Dir | Fields
// req     | in  | command, amount, start_day, start_month, start_year
// rsp     | out | end_day, end_month, end_year, overflow, bad_date
//
// One request at a time: setup steps (capture, year split multiply, split, check),
// then one cycle per day through the shared day stepper, or a single year addition.
// Weeks step 7 * amount days, months step each month by its length in days; an invalid
// date or unused command skips the stepper. The result is loaded at the end.
// Reset clears the sequencer and the result valid; no clearing pass is needed.
// The result sits in an output register, so a new request is taken while it stalls.
`default_nettype none
module gregorian_date_adder (
	input  var logic clk,
	input  var logic arst_n,
	gda_in_if.sink   req,
	gda_out_if.source rsp
);

	gda_pkg::date_t cur;
	gda_pkg::step_t step;

	gda_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.command     (req.command),
		.amount      (req.amount),
		.start_day   (req.start_day),
		.start_month (req.start_month),
		.start_year  (req.start_year),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.end_day     (rsp.end_day),
		.end_month   (rsp.end_month),
		.end_year    (rsp.end_year),
		.overflow    (rsp.overflow),
		.bad_date    (rsp.bad_date),
		.cur         (cur),
		.step        (step)
	);

	gda_day_unit u_day (
		.cur  (cur),
		.step (step)
	);

endmodule
`default_nettype wire

### sv/gda_checker.sv
`default_nettype none
module gda_checker (
	input var logic                         clk,
	input var logic                         arst_n,
	input var logic                         in_valid,
	input var logic                         in_ready,
	input var logic                         out_valid,
	input var logic                         out_ready,
	input var logic [gda_pkg::DAY_W-1:0]  end_day,
	input var logic [gda_pkg::MON_W-1:0]  end_month,
	input var logic [gda_pkg::YEAR_W-1:0] end_year,
	input var logic                         overflow,
	input var logic                         bad_date
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(end_day) && $stable(end_month)
			&& $stable(end_year) && $stable(overflow) && $stable(bad_date))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while one is in progress");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(overflow && bad_date))
		else $error("overflow set on an invalid date");

	a_valid_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_date |-> (end_month != '0) && (end_month <= gda_pkg::MON_DEC)
			&& (end_day != '0) && (end_year != '0))
		else $error("result date out of range");

endmodule

bind gregorian_date_adder gda_checker u_gda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.end_day   (rsp.end_day),
	.end_month (rsp.end_month),
	.end_year  (rsp.end_year),
	.overflow  (rsp.overflow),
	.bad_date  (rsp.bad_date)
);
`default_nettype wire
